/* design/u8vt_pkg.sv */
// types, codes and small helper functions for the utf-8 validating transcoder
// used by u8vt_decode, u8vt_emit and utf8_validating_transcoder
// no dependencies
package u8vt_pkg;

   localparam int BYTE_W = 8;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 3;
   localparam int NUM_SEGS = 5;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CODEC = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_ERR_MODE = 1'b1;

   typedef enum logic [1:0] {
      FMT_UTF8      = 2'd0,
      FMT_UTF8_MARK = 2'd1,
      FMT_ASCII     = 2'd2,
      FMT_LATIN1    = 2'd3
   } codec_type;

   typedef enum logic [2:0] {
      ERR_STRICT      = 3'd0,
      ERR_IGNORE      = 3'd1,
      ERR_REPLACE     = 3'd2,
      ERR_BACKSLASH   = 3'd3,
      ERR_XMLCHAR     = 3'd4,
      ERR_UNSUPPORTED = 3'd5,
      ERR_UNKNOWN     = 3'd6,
      ERR_RESERVED    = 3'd7
   } err_mode_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_UNICODE = 2'd1,
      STAT_TYPE    = 2'd2,
      STAT_LOOKUP  = 2'd3
   } status_type;

   // kind of one output segment
   typedef enum logic [1:0] {
      SEG_PASS = 2'd0,   // bytes copied out as they are
      SEG_REPL = 2'd1,   // replacement character ef bf bd
      SEG_ESC  = 2'd2,   // \xhh for each held byte
      SEG_STAT = 2'd3    // status or bare end marker, no byte
   } seg_kind_type;

   typedef struct packed {
      seg_kind_type            kind;
      logic [3:0]              len;
      logic [3:0][BYTE_W-1:0]  data;
   } seg_type;

   // everything one request expands into, in output order
   typedef struct packed {
      seg_type [NUM_SEGS-1:0] seg;
      logic                   last;
   } plan_type;

   typedef struct packed {
      logic              ok;
      logic [1:0]        need;
      logic [BYTE_W-1:0] lo;
      logic [BYTE_W-1:0] hi;
   } lead_type;

   localparam logic [BYTE_W-1:0] CONT_LO    = 8'h80;
   localparam logic [BYTE_W-1:0] CONT_HI    = 8'hBF;
   localparam logic [BYTE_W-1:0] LEAD2_LO   = 8'hC2;
   localparam logic [BYTE_W-1:0] LEAD2_HI   = 8'hDF;
   localparam logic [BYTE_W-1:0] LEAD_E0    = 8'hE0;
   localparam logic [BYTE_W-1:0] LEAD_ED    = 8'hED;
   localparam logic [BYTE_W-1:0] LEAD_EF    = 8'hEF;
   localparam logic [BYTE_W-1:0] LEAD_F0    = 8'hF0;
   localparam logic [BYTE_W-1:0] LEAD_F4    = 8'hF4;
   localparam logic [BYTE_W-1:0] E0_LO      = 8'hA0;
   localparam logic [BYTE_W-1:0] ED_HI      = 8'h9F;
   localparam logic [BYTE_W-1:0] F0_LO      = 8'h90;
   localparam logic [BYTE_W-1:0] F4_HI      = 8'h8F;
   localparam logic [BYTE_W-1:0] BOM_1      = 8'hBB;
   localparam logic [BYTE_W-1:0] BOM_2      = 8'hBF;
   localparam logic [BYTE_W-1:0] REPL_0     = 8'hEF;
   localparam logic [BYTE_W-1:0] REPL_1     = 8'hBF;
   localparam logic [BYTE_W-1:0] REPL_2     = 8'hBD;
   localparam logic [BYTE_W-1:0] CHAR_BSL   = 8'h5C;
   localparam logic [BYTE_W-1:0] CHAR_X     = 8'h78;

   function automatic lead_type lead_info(input logic [BYTE_W-1:0] b);
      lead_type r;
      r.ok   = 1'b1;
      r.need = 2'd0;
      r.lo   = CONT_LO;
      r.hi   = CONT_HI;
      if (b >= LEAD2_LO && b <= LEAD2_HI) begin
         r.need = 2'd1;
      end else if (b == LEAD_E0) begin
         r.need = 2'd2;
         r.lo   = E0_LO;
      end else if (b == LEAD_ED) begin
         r.need = 2'd2;
         r.hi   = ED_HI;
      end else if (b > LEAD_E0 && b <= LEAD_EF) begin
         r.need = 2'd2;
      end else if (b == LEAD_F0) begin
         r.need = 2'd3;
         r.lo   = F0_LO;
      end else if (b == LEAD_F4) begin
         r.need = 2'd3;
         r.hi   = F4_HI;
      end else if (b > LEAD_F0 && b < LEAD_F4) begin
         r.need = 2'd3;
      end else begin
         r.ok = 1'b0;
      end
      return r;
   endfunction

   function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] v);
      logic [BYTE_W-1:0] r;
      if (v < 4'd10) r = 8'h30 + {4'd0, v};
      else r = 8'h57 + {4'd0, v};
      return r;
   endfunction

endpackage

/* design/u8vt_decode.sv */
// request register, stream state and configuration registers; expands the held
// request into an ordered list of output segments
// depends on u8vt_pkg
module u8vt_decode (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [u8vt_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [u8vt_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [u8vt_pkg::BYTE_W-1:0]    req_tdata,
   input  logic                           req_tlast,
   input  logic                           commit,
   output logic                           item_vld,
   output u8vt_pkg::plan_type             plan
);
   import u8vt_pkg::*;

   logic                  item_vld_ff;
   logic [BYTE_W-1:0]     byte_ff;
   logic                  last_ff;
   logic [BYTE_W-1:0]     pend_ff [3];
   logic [BYTE_W-1:0]     pend_in [3];
   logic [1:0]            cnt_ff, cnt_in;
   logic [1:0]            need_ff, need_in;
   logic                  start_ff, start_in;
   logic                  halt_ff, halt_in;
   codec_type             codec_ff;
   err_mode_type          mode_ff;

   lead_type              li_b, li_p;
   logic [BYTE_W-1:0]     lo, hi;
   logic                  in_rng, lead_now, mark, is_utf8;
   logic                  s0_on, s1_on, s2_on, s3_on;
   logic [2:0]            s2_n;
   logic [3:0][BYTE_W-1:0] s2_data;
   logic                  halting, early, halt, any;
   status_type            halt_st;

   function automatic seg_type make_span(input logic on, input logic [3:0][BYTE_W-1:0] d,
                                         input logic [1:0] n, input err_mode_type m);
      seg_type s;
      s.kind = SEG_REPL;
      s.len  = 4'd0;
      s.data = d;
      if (on && n != 2'd0) begin
         case (m)
            ERR_REPLACE: begin
               s.kind = SEG_REPL;
               s.len  = 4'd3;
            end
            ERR_BACKSLASH: begin
               s.kind = SEG_ESC;
               s.len  = {n, 2'b00};
            end
            default: s.len = 4'd0;
         endcase
      end
      return s;
   endfunction

   assign req_tready = !item_vld_ff || commit;
   assign item_vld   = item_vld_ff;
   assign is_utf8    = (codec_ff == FMT_UTF8) || (codec_ff == FMT_UTF8_MARK);

   always_comb begin
      li_b     = lead_info(byte_ff);
      li_p     = lead_info(pend_ff[0]);
      lo       = (cnt_ff == 2'd1) ? li_p.lo : CONT_LO;
      hi       = (cnt_ff == 2'd1) ? li_p.hi : CONT_HI;
      in_rng   = (byte_ff >= lo) && (byte_ff <= hi);
      cnt_in   = cnt_ff;
      need_in  = need_ff;
      pend_in  = pend_ff;
      start_in = start_ff;
      s0_on    = 1'b0;
      s1_on    = 1'b0;
      s2_on    = 1'b0;
      s2_n     = 3'd1;
      s2_data  = '0;
      lead_now = 1'b0;
      mark     = 1'b0;
      if (is_utf8) begin
         if (cnt_ff == 2'd0) begin
            lead_now = 1'b1;
         end else if (!in_rng) begin
            // held bytes become a bad span, the byte is looked at again as a lead
            s0_on    = 1'b1;
            lead_now = 1'b1;
            cnt_in   = 2'd0;
            need_in  = 2'd0;
            start_in = 1'b0;
         end else if (cnt_ff >= need_ff) begin
            mark = (codec_ff == FMT_UTF8_MARK) && start_ff && (cnt_ff == 2'd2) &&
                   (pend_ff[0] == LEAD_EF) && (pend_ff[1] == BOM_1) && (byte_ff == BOM_2);
            s2_on      = !mark;
            s2_n       = {1'b0, cnt_ff} + 3'd1;
            s2_data[0] = pend_ff[0];
            s2_data[1] = (cnt_ff > 2'd1) ? pend_ff[1] : byte_ff;
            s2_data[2] = (cnt_ff > 2'd2) ? pend_ff[2] : byte_ff;
            s2_data[3] = byte_ff;
            cnt_in     = 2'd0;
            need_in    = 2'd0;
            start_in   = 1'b0;
         end else begin
            case (cnt_ff)
               2'd1:    pend_in[1] = byte_ff;
               default: pend_in[2] = byte_ff;
            endcase
            cnt_in = cnt_ff + 2'd1;
         end
         if (lead_now) begin
            if (!byte_ff[7]) begin
               s2_on      = 1'b1;
               s2_n       = 3'd1;
               s2_data[0] = byte_ff;
               start_in   = 1'b0;
            end else if (li_b.ok) begin
               pend_in[0] = byte_ff;
               cnt_in     = 2'd1;
               need_in    = li_b.need;
            end else begin
               s1_on    = 1'b1;
               start_in = 1'b0;
            end
         end
      end else begin
         s0_on    = (cnt_ff != 2'd0);
         cnt_in   = 2'd0;
         need_in  = 2'd0;
         start_in = 1'b0;
         if (!byte_ff[7]) begin
            s2_on      = 1'b1;
            s2_n       = 3'd1;
            s2_data[0] = byte_ff;
         end else if (codec_ff == FMT_LATIN1) begin
            s2_on      = 1'b1;
            s2_n       = 3'd2;
            s2_data[0] = {6'b110000, byte_ff[7:6]};
            s2_data[1] = {2'b10, byte_ff[5:0]};
         end else begin
            s1_on = 1'b1;
         end
      end
      s3_on = last_ff && (cnt_in != 2'd0);
   end

   always_comb begin
      case (mode_ff)
         ERR_IGNORE, ERR_REPLACE, ERR_BACKSLASH: halting = 1'b0;
         default:                                halting = 1'b1;
      endcase
      case (mode_ff)
         ERR_XMLCHAR:               halt_st = STAT_TYPE;
         ERR_UNKNOWN, ERR_RESERVED: halt_st = STAT_LOOKUP;
         default:                   halt_st = STAT_UNICODE;
      endcase
      // a halting span drops whatever the request would produce after it
      early   = halting && (s0_on || s1_on);
      halt    = !halt_ff && halting && (s0_on || s1_on || s3_on);
      halt_in = halt && !last_ff;

      plan.last   = last_ff;
      plan.seg[0] = make_span(!halt_ff && s0_on,
                              {8'd0, pend_ff[2], pend_ff[1], pend_ff[0]}, cnt_ff, mode_ff);
      plan.seg[1] = make_span(!halt_ff && s1_on, {24'd0, byte_ff}, 2'd1, mode_ff);
      plan.seg[2].kind = SEG_PASS;
      plan.seg[2].data = s2_data;
      plan.seg[2].len  = (!halt_ff && s2_on && !early) ? {1'b0, s2_n} : 4'd0;
      plan.seg[3] = make_span(!halt_ff && s3_on,
                              {8'd0, pend_in[2], pend_in[1], pend_in[0]}, cnt_in, mode_ff);
      any = (plan.seg[0].len != 4'd0) || (plan.seg[1].len != 4'd0) ||
            (plan.seg[2].len != 4'd0) || (plan.seg[3].len != 4'd0);
      plan.seg[4].kind = SEG_STAT;
      plan.seg[4].data = {24'd0, 6'd0, halt ? halt_st : STAT_OK};
      plan.seg[4].len  = (halt || (last_ff && !any)) ? 4'd1 : 4'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         cnt_ff      <= 2'd0;
         need_ff     <= 2'd0;
         start_ff    <= 1'b1;
         halt_ff     <= 1'b0;
         codec_ff    <= FMT_UTF8;
         mode_ff     <= ERR_STRICT;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_CODEC:    codec_ff <= codec_type'(csr_wdata[1:0]);
               REG_ERR_MODE: mode_ff  <= err_mode_type'(csr_wdata);
               default:      ;
            endcase
         end
         if (req_tready) item_vld_ff <= req_tvalid;
         if (commit) begin
            if (last_ff) begin
               cnt_ff   <= 2'd0;
               need_ff  <= 2'd0;
               start_ff <= 1'b1;
               halt_ff  <= 1'b0;
            end else if (!halt_ff) begin
               cnt_ff   <= cnt_in;
               need_ff  <= need_in;
               start_ff <= start_in;
               halt_ff  <= halt_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         byte_ff <= req_tdata;
         last_ff <= req_tlast;
      end
      if (commit && !halt_ff) pend_ff <= pend_in;
   end

endmodule

/* design/u8vt_emit.sv */
// walks the segment list of the held request into the response register, one output byte
// per cycle while the response register can be loaded
// depends on u8vt_pkg
module u8vt_emit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        item_vld,
   input  u8vt_pkg::plan_type          plan,
   output logic                        commit,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [u8vt_pkg::BYTE_W-1:0] rsp_tdata,
   output logic                        rsp_tlast,
   output logic [3:0]                  rsp_tuser
);
   import u8vt_pkg::*;

   logic [NUM_SEGS-1:0] done_ff;
   logic [3:0]          sub_ff;
   logic                rsp_vld_ff;
   logic [BYTE_W-1:0]   rsp_byte_ff;
   logic                rsp_bvld_ff, rsp_run_ff, rsp_done_ff;
   status_type          rsp_st_ff;

   logic [NUM_SEGS-1:0] live, rest, cur_bit;
   logic [2:0]          cur;
   logic                has, can_load, emit, seg_end, fin;
   seg_type             cs;
   logic [BYTE_W-1:0]   esc_src, elem;
   logic                elem_vld;
   status_type          elem_st;

   always_comb begin
      for (int i = 0; i < NUM_SEGS; i++) live[i] = (plan.seg[i].len != 4'd0) && !done_ff[i];
      cur = 3'd0;
      for (int i = NUM_SEGS - 1; i >= 0; i--) begin
         if (live[i]) cur = 3'(i);
      end
      cur_bit  = NUM_SEGS'(1) << cur;
      rest     = live & ~cur_bit;
      has      = |live;
      cs       = plan.seg[cur];
      can_load = !rsp_vld_ff || rsp_tready;
      emit     = item_vld && has && can_load;
      seg_end  = (sub_ff == cs.len - 4'd1);
      fin      = seg_end && (rest == '0);
      commit   = item_vld && (!has || (emit && fin));

      esc_src  = cs.data[sub_ff[3:2]];
      elem     = 8'd0;
      elem_vld = 1'b1;
      elem_st  = STAT_OK;
      case (cs.kind)
         SEG_PASS: elem = cs.data[sub_ff[1:0]];
         SEG_REPL: begin
            case (sub_ff[1:0])
               2'd0:    elem = REPL_0;
               2'd1:    elem = REPL_1;
               default: elem = REPL_2;
            endcase
         end
         SEG_ESC: begin
            case (sub_ff[1:0])
               2'd0:    elem = CHAR_BSL;
               2'd1:    elem = CHAR_X;
               2'd2:    elem = hex_digit(esc_src[7:4]);
               default: elem = hex_digit(esc_src[3:0]);
            endcase
         end
         default: begin
            elem_vld = 1'b0;
            elem_st  = status_type'(cs.data[0][1:0]);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff    <= '0;
         sub_ff     <= 4'd0;
         rsp_vld_ff <= 1'b0;
      end else begin
         if (commit) begin
            done_ff <= '0;
            sub_ff  <= 4'd0;
         end else if (emit) begin
            if (seg_end) begin
               done_ff <= done_ff | cur_bit;
               sub_ff  <= 4'd0;
            end else begin
               sub_ff <= sub_ff + 4'd1;
            end
         end
         if (emit) rsp_vld_ff <= 1'b1;
         else if (rsp_tready) rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_byte_ff <= elem;
         rsp_bvld_ff <= elem_vld;
         rsp_st_ff   <= elem_st;
         rsp_run_ff  <= fin;
         rsp_done_ff <= fin && plan.last;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tlast  = rsp_done_ff;
   assign rsp_tuser  = {rsp_st_ff, rsp_run_ff, rsp_bvld_ff};

   // a marker result carries no byte
   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && !rsp_bvld_ff |-> rsp_byte_ff == 8'd0)
      else $error("marker result with nonzero byte");

   // end of stream is always also end of the request's results
   a_done_run: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff && rsp_done_ff |-> rsp_run_ff)
      else $error("stream end without request end");

   // a final request always produces at least one result
   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      item_vld && plan.last && done_ff == '0 |-> has)
      else $error("final request with no results");

   // segment progress only exists while a request is held
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      !item_vld |-> done_ff == '0 && sub_ff == 4'd0)
      else $error("stale segment progress");

   // after the final result of a request the next one starts clean
   a_commit_clear: assert property (@(posedge clock) disable iff (reset)
      commit |=> done_ff == '0)
      else $error("progress not cleared after commit");

endmodule

/* design/utf8_validating_transcoder.sv */
// top level of the utf-8 validating transcoder
// depends on u8vt_pkg, u8vt_decode, u8vt_emit
//
//  channel  dir  handshake              payload
//  req      in   req_tvalid/req_tready  tdata in_byte, tlast stream_last
//  rsp      out  rsp_tvalid/rsp_tready  tdata text_byte, tlast stream_done,
//                                       tuser byte_valid, run_last, status
//  csr      in   csr_we                 csr_index, csr_wdata (codec, error_mode)
//
// a request stays in the request register until its final result is loaded through the
// single response register port, one result at a time; a request that gives no result
// (a held multi-byte lead or continuation) leaves without waiting on the response side.
// bytes below 0x80 therefore run at one byte per cycle while the response is not stalled.
// reset is synchronous and clears the stream state and both registers to utf8 / strict.
// a stalled response stalls the walk; the request side is ready while none is held, or
// while the held one gives no result or is on its final result and the response is free.
module utf8_validating_transcoder (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_we,
   input  logic [u8vt_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [u8vt_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [u8vt_pkg::BYTE_W-1:0]     req_tdata,   // [7:0] in_byte
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [u8vt_pkg::BYTE_W-1:0]     rsp_tdata,   // [7:0] text_byte
   output logic                            rsp_tlast,
   output logic [3:0]                      rsp_tuser    // [0] byte_valid, [1] run_last,
                                                        // [3:2] status
);
   import u8vt_pkg::*;

   plan_type plan;
   logic     commit;
   logic     item_vld;

   u8vt_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .commit     (commit),
      .item_vld   (item_vld),
      .plan       (plan)
   );

   u8vt_emit u_emit (
      .clock      (clock),
      .reset      (reset),
      .item_vld   (item_vld),
      .plan       (plan),
      .commit     (commit),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

/* sim/tb.sv */
// testbench for utf8_validating_transcoder: feeds byte streams under every codec and every
// error mode but reserved, predicts the text bytes and status of each request and checks
// each response in order; depends on u8vt_pkg and the utf8_validating_transcoder rtl
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import u8vt_pkg::*;

   localparam int RANDOM_ITEMS = 230;
   localparam int QUIET_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 8;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
      int         gap;
      bit         drain;
   } byte_req_type;

   typedef struct packed {
      logic [7:0] text;
      logic       valid;
      logic       run_last;
      logic       done;
      status_type status;
   } text_out_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [BYTE_W-1:0]     req_tdata = '0;     // [7:0] in_byte
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [BYTE_W-1:0]     rsp_tdata;          // [7:0] text_byte
   logic                  rsp_tlast;
   logic [3:0]            rsp_tuser;          // [0] byte_valid, [1] run_last, [3:2] status

   utf8_validating_transcoder DUT (.*);

   // predictor state
   logic [7:0]   held [3];
   int           held_count = 0;
   int           held_need = 0;
   bit           at_start = 1'b1;
   bit           halted = 1'b0;
   codec_type    cur_codec = FMT_UTF8;
   err_mode_type cur_mode = ERR_STRICT;
   text_out_type step_text[$];
   text_out_type expected_text[$];

   byte_req_type outgoing[$];
   logic [7:0]   stream_bytes[$];
   int           queued_count = 0;
   int           accepted_count = 0;
   int           fail_count = 0;
   bit           calm = 1'b0;
   bit           feeding = 1'b0;
   int           gap_count = 0;
   int           stall_count = 0;
   int           quiet_cycles = 0;

   initial forever #5 clock = ~clock;

   function automatic void put_text(input logic [7:0] v, input logic ok, input status_type st);
      text_out_type r;
      r.text = v;
      r.valid = ok;
      r.run_last = 1'b0;
      r.done = 1'b0;
      r.status = st;
      step_text.push_back(r);
   endfunction

   function automatic void put_byte(input logic [7:0] v);
      put_text(v, 1'b1, STAT_OK);
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      return (v < 4'd10) ? 8'h30 + {4'd0, v} : 8'h57 + {4'd0, v};
   endfunction

   // number of continuation bytes and allowed range of the first continuation for a lead byte
   function automatic bit lead_limits(input logic [7:0] b, output int need,
                                      output logic [7:0] lo, output logic [7:0] hi);
      lo = 8'h80;
      hi = 8'hBF;
      need = 0;
      if (b >= 8'hC2 && b <= 8'hDF) need = 1;
      else if (b >= 8'hE0 && b <= 8'hEF) need = 2;
      else if (b >= 8'hF0 && b <= 8'hF4) need = 3;
      else return 1'b0;
      if (b == 8'hE0) lo = 8'hA0;
      if (b == 8'hED) hi = 8'h9F;
      if (b == 8'hF0) lo = 8'h90;
      if (b == 8'hF4) hi = 8'h8F;
      return 1'b1;
   endfunction

   function automatic status_type bad_span(input logic [7:0] span [3], input int n);
      status_type st;
      st = STAT_OK;
      case (cur_mode)
         ERR_IGNORE: ;
         ERR_REPLACE: begin
            put_byte(8'hEF);
            put_byte(8'hBF);
            put_byte(8'hBD);
         end
         ERR_BACKSLASH: begin
            for (int k = 0; k < n; k++) begin
               put_byte(8'h5C);
               put_byte(8'h78);
               put_byte(hex_char(span[k][7:4]));
               put_byte(hex_char(span[k][3:0]));
            end
         end
         ERR_XMLCHAR: st = STAT_TYPE;
         ERR_UNKNOWN, ERR_RESERVED: st = STAT_LOOKUP;
         default: st = STAT_UNICODE;
      endcase
      return st;
   endfunction

   function automatic status_type flush_held();
      int n;
      n = held_count;
      held_count = 0;
      held_need = 0;
      at_start = 1'b0;
      return bad_span(held, n);
   endfunction

   function automatic status_type take_lead(input logic [7:0] b);
      int         need;
      logic [7:0] lo, hi;
      logic [7:0] span [3];
      if (b < 8'h80) begin
         put_byte(b);
         at_start = 1'b0;
         return STAT_OK;
      end
      if (!lead_limits(b, need, lo, hi)) begin
         at_start = 1'b0;
         span[0] = b;
         return bad_span(span, 1);
      end
      held[0] = b;
      held_count = 1;
      held_need = need;
      return STAT_OK;
   endfunction

   function automatic status_type feed_utf8(input logic [7:0] b);
      int         need;
      logic [7:0] lo, hi;
      status_type st;
      bit         bom;
      if (held_count == 0) return take_lead(b);
      lo = 8'h80;
      hi = 8'hBF;
      if (held_count == 1) void'(lead_limits(held[0], need, lo, hi));
      if (b < lo || b > hi) begin
         // the failing byte gets a second look as a lead
         st = flush_held();
         if (st != STAT_OK) return st;
         return take_lead(b);
      end
      if (held_count >= held_need) begin
         bom = cur_codec == FMT_UTF8_MARK && at_start && held_count == 2 &&
               held[0] == 8'hEF && held[1] == 8'hBB && b == 8'hBF;
         if (!bom) begin
            for (int j = 0; j < held_count; j++) put_byte(held[j]);
            put_byte(b);
         end
         held_count = 0;
         held_need = 0;
         at_start = 1'b0;
         return STAT_OK;
      end
      held[held_count] = b;
      held_count++;
      return STAT_OK;
   endfunction

   // expected responses of one accepted request
   function automatic void transcode_step(input logic [7:0] b, input logic last);
      status_type st;
      st = STAT_OK;
      step_text.delete();
      if (!halted) begin
         if (cur_codec >= FMT_ASCII && held_count > 0) st = flush_held();
         if (st == STAT_OK) begin
            case (cur_codec)
               FMT_LATIN1: begin
                  if (b < 8'h80) put_byte(b);
                  else begin
                     put_byte(8'hC0 | (b >> 6));
                     put_byte(8'h80 | (b & 8'h3F));
                  end
                  at_start = 1'b0;
               end
               FMT_ASCII: begin
                  at_start = 1'b0;
                  if (b < 8'h80) put_byte(b);
                  else begin
                     held[0] = b;
                     st = bad_span(held, 1);
                  end
               end
               default: st = feed_utf8(b);
            endcase
         end
         if (st == STAT_OK && last && held_count > 0) st = flush_held();
         if (st != STAT_OK) begin
            put_text(8'h00, 1'b0, st);
            if (!last) halted = 1'b1;
         end
      end
      if (step_text.size() == 0 && last) put_text(8'h00, 1'b0, STAT_OK);
      if (step_text.size() > 0) begin
         step_text[step_text.size()-1].run_last = 1'b1;
         step_text[step_text.size()-1].done = last;
      end
      foreach (step_text[i]) expected_text.push_back(step_text[i]);
      if (last) begin
         held_count = 0;
         held_need = 0;
         at_start = 1'b1;
         halted = 1'b0;
      end
   endfunction

   function automatic int pause_draw();
      if (calm || $urandom_range(0, 1) == 0) return 0;
      return $urandom_range(0, 19);
   endfunction

   function automatic void check_field(input string field, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
         fail_count++;
      end
   endfunction

   // one character, well formed or broken, appended to the stream under construction
   function automatic void add_char(input bit broken);
      logic [7:0] seq [4];
      int         len, need;
      logic [7:0] lo, hi;
      case ($urandom_range(0, 3))
         0: begin seq[0] = 8'($urandom_range(0, 127)); len = 1; end
         1: begin seq[0] = 8'($urandom_range(8'hC2, 8'hDF)); len = 2; end
         2: begin seq[0] = 8'($urandom_range(8'hE0, 8'hEF)); len = 3; end
         default: begin seq[0] = 8'($urandom_range(8'hF0, 8'hF4)); len = 4; end
      endcase
      void'(lead_limits(seq[0], need, lo, hi));
      seq[1] = 8'($urandom_range(lo, hi));
      seq[2] = 8'($urandom_range(8'h80, 8'hBF));
      seq[3] = 8'($urandom_range(8'h80, 8'hBF));
      if (broken) begin
         if (len == 1) begin
            if ($urandom_range(0, 1) == 0) seq[0] = 8'($urandom_range(8'h80, 8'hC1));
            else seq[0] = 8'($urandom_range(8'hF5, 8'hFF));
         end else if ($urandom_range(0, 1) == 0) len = $urandom_range(1, len - 1);
         else seq[$urandom_range(1, len - 1)] = 8'($urandom_range(0, 255));
      end
      for (int k = 0; k < len; k++) stream_bytes.push_back(seq[k]);
   endfunction

   task automatic queue_stream(input bit close, input bit drain);
      byte_req_type r;
      for (int i = 0; i < stream_bytes.size(); i++) begin
         r.data = stream_bytes[i];
         r.last = close && i == stream_bytes.size() - 1;
         r.gap = pause_draw();
         r.drain = drain && i == 0;
         outgoing.push_back(r);
         queued_count++;
      end
      stream_bytes.delete();
   endtask

   // an open stream ends on a bare lead so that the next codec write finds bytes held
   task automatic build_stream(input bit close);
      int r;
      if ($urandom_range(0, 4) == 0) stream_bytes = '{8'hEF, 8'hBB, 8'hBF};
      repeat ($urandom_range(1, 6)) begin
         r = $urandom_range(0, 9);
         if (r < 6) add_char(1'b0);
         else if (r < 8) add_char(1'b1);
         else stream_bytes.push_back(8'($urandom_range(0, 255)));
      end
      if (!close) stream_bytes.push_back(8'($urandom_range(8'hC2, 8'hF4)));
      queue_stream(close, $urandom_range(0, 9) == 0);
   endtask

   task automatic settle();
      do @(posedge clock);
      while (accepted_count != queued_count || expected_text.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_CODEC) cur_codec = codec_type'(value[1:0]);
      else cur_mode = err_mode_type'(value);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata <= '0;
         req_tlast <= 1'b0;
         feeding = 1'b0;
         gap_count = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            transcode_step(req_tdata, req_tlast);
            accepted_count++;
            feeding = 1'b0;
         end
         if (!feeding && outgoing.size() != 0) begin
            if (gap_count < outgoing[0].gap) gap_count++;
            else if (!outgoing[0].drain || expected_text.size() == 0) begin
               req_tdata <= outgoing[0].data;
               req_tlast <= outgoing[0].last;
               outgoing.delete(0);
               gap_count = 0;
               feeding = 1'b1;
            end
         end
         req_tvalid <= feeding;
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_text.size() == 0) begin
               $error("unexpected response: tdata 0x%0h tuser 0x%0h tlast %0b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               fail_count++;
            end else begin
               check_field("text_byte", expected_text[0].text, rsp_tdata);
               check_field("byte_valid", 8'(expected_text[0].valid), 8'(rsp_tuser[0]));
               check_field("run_last", 8'(expected_text[0].run_last), 8'(rsp_tuser[1]));
               check_field("stream_done", 8'(expected_text[0].done), 8'(rsp_tlast));
               check_field("status", 8'(expected_text[0].status), 8'(rsp_tuser[3:2]));
               expected_text.delete(0);
            end
            stall_count = pause_draw();
         end
         if (stall_count > 0) begin
            stall_count--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
            quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $error("no handshake for %0d cycles", QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      int phase;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // boundary lengths and the narrowed first-continuation ranges
      write_reg(REG_CODEC, CSR_DATA_W'(FMT_UTF8));
      write_reg(REG_ERR_MODE, CSR_DATA_W'(ERR_REPLACE));
      stream_bytes = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
                       8'hE0, 8'h9F, 8'hED, 8'hA0, 8'hF0, 8'h8F, 8'hFF, 8'hC3};
      queue_stream(1'b1, 1'b0);
      settle();

      // leading mark dropped, truncated tail escaped, mark-only stream gives a bare end
      write_reg(REG_CODEC, CSR_DATA_W'(FMT_UTF8_MARK));
      write_reg(REG_ERR_MODE, CSR_DATA_W'(ERR_BACKSLASH));
      stream_bytes = '{8'hEF, 8'hBB, 8'hBF, 8'h41, 8'hE2};
      queue_stream(1'b1, 1'b0);
      stream_bytes = '{8'hEF, 8'hBB, 8'hBF};
      queue_stream(1'b1, 1'b0);
      settle();

      // halt on a high byte, discard until the end flag
      write_reg(REG_CODEC, CSR_DATA_W'(FMT_ASCII));
      write_reg(REG_ERR_MODE, CSR_DATA_W'(ERR_STRICT));
      stream_bytes = '{8'h41, 8'h80, 8'h42, 8'h43};
      queue_stream(1'b1, 1'b1);
      settle();

      write_reg(REG_CODEC, CSR_DATA_W'(FMT_LATIN1));
      write_reg(REG_ERR_MODE, CSR_DATA_W'(ERR_XMLCHAR));
      stream_bytes = '{8'h80, 8'hFF};
      queue_stream(1'b1, 1'b0);

      phase = 0;
      while (queued_count < RANDOM_ITEMS) begin
         settle();
         write_reg(REG_CODEC, CSR_DATA_W'((phase < 4) ? phase : $urandom_range(0, 3)));
         write_reg(REG_ERR_MODE, CSR_DATA_W'((phase < 7) ? phase : $urandom_range(0, 6)));
         calm = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(2, 5)) build_stream(1'b1);
         if ($urandom_range(0, 2) == 0) build_stream(1'b0);
         phase++;
      end
      settle();

      if (fail_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

/* utf8_validating_transcoder.f */
design/u8vt_pkg.sv
design/u8vt_decode.sv
design/u8vt_emit.sv
design/utf8_validating_transcoder.sv
sim/tb.sv
